### hw/rtl/two_sided_gaussian_membership_core_macros.svh
// Assertion macros for the two-sided Gaussian membership core.
// Included by files that carry concurrent assertions; needs clock and reset in scope.
`ifndef TWO_SIDED_GAUSSIAN_MEMBERSHIP_CORE_MACROS_SVH
`define TWO_SIDED_GAUSSIAN_MEMBERSHIP_CORE_MACROS_SVH

// condition holds at every edge outside reset
`define TSGM_ASSERT_ALWAYS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) else $error(msg);

// same-cycle implication
`define TSGM_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define TSGM_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### hw/rtl/tsgm_pkg.sv
// Shared types, constants and table functions of the two-sided Gaussian membership core.
// No dependencies.
package tsgm_pkg;

   localparam int EXP_TABLE_DEPTH_DEF = 256;

   localparam int STAGES    = 7;
   localparam int ST_DIFF   = 0;
   localparam int ST_SQUARE = 1;
   localparam int ST_SCALE  = 2;
   localparam int ST_INDEX  = 3;
   localparam int ST_READ   = 4;
   localparam int ST_INTERP = 5;
   localparam int ST_OUT    = 6;

   localparam int SIDE_W = 31;   // Q1.30
   localparam int FRAC_W = 16;
   localparam int EXP_FRAC_BITS = 36;   // exponent a carries 32 fraction bits, limit 16.0

   localparam logic [SIDE_W-1:0] SIDE_ONE = SIDE_W'(1) << 30;
   localparam logic [15:0]       MEMBERSHIP_ONE = 16'h8000;

   localparam logic [15:0] CENTER_RESET  = 16'h0000;
   localparam logic [23:0] FALLOFF_RESET = 24'h010000;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 24;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LEFT_CENTER,
      CSR_RIGHT_CENTER,
      CSR_LEFT_FALLOFF,
      CSR_RIGHT_FALLOFF
   } csr_index_type;

   typedef logic [STAGES-1:0] stage_en_type;

   typedef struct packed {
      logic active;   // sample lies on the falloff side of the center
      logic sat;      // exponent at or above sixteen
   } side_flags_type;

   localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

   function automatic logic [63:0] div_small(input logic [63:0] v, input int k);
      logic [63:0] q;
      case (k)
         2:       q = v / 2;
         3:       q = v / 3;
         4:       q = v / 4;
         5:       q = v / 5;
         6:       q = v / 6;
         7:       q = v / 7;
         8:       q = v / 8;
         9:       q = v / 9;
         10:      q = v / 10;
         11:      q = v / 11;
         12:      q = v / 12;
         default: q = v;
      endcase
      return q;
   endfunction

   // exp(-z) in Q2.30: twelve Taylor terms, then five squarings
   function automatic logic [63:0] exp_entry(input logic [63:0] z);
      logic [63:0] sum;
      logic [63:0] term;
      sum  = ONE_Q30;
      term = ONE_Q30;
      for (int k = 1; k <= 12; k++) begin
         term = div_small((term * z) >> 30, k);
         if (k[0]) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      for (int n = 0; n < 5; n++) begin
         sum = (sum * sum + (ONE_Q30 >> 1)) >> 30;
      end
      return sum;
   endfunction

endpackage

### hw/rtl/tsgm_exp_interp.sv
// Exponential table read and linear interpolation for one side (two stages).
// Depends on tsgm_pkg; table contents are built at elaboration.
module tsgm_exp_interp import tsgm_pkg::*; #(
   parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
   input  logic                               clock,
   input  stage_en_type                       ld,
   input  logic [$clog2(EXP_TABLE_DEPTH)-1:0] idx,
   input  logic [FRAC_W-1:0]                  frac,
   input  side_flags_type                     flags,
   output logic [SIDE_W-1:0]                  side_value
);

   localparam int IDX_W = $clog2(EXP_TABLE_DEPTH);

   logic [SIDE_W-1:0] hi_rom    [EXP_TABLE_DEPTH];
   logic [SIDE_W-1:0] delta_rom [EXP_TABLE_DEPTH];

   for (genvar i = 0; i < EXP_TABLE_DEPTH; i++) begin : g_rom
      localparam logic [63:0] Z_HI = ((64'(i) << 30) + 64'(EXP_TABLE_DEPTH))
                                     / 64'(2 * EXP_TABLE_DEPTH);
      localparam logic [63:0] Z_LO = ((64'(i + 1) << 30) + 64'(EXP_TABLE_DEPTH))
                                     / 64'(2 * EXP_TABLE_DEPTH);
      localparam logic [63:0] T_HI = exp_entry(Z_HI);
      localparam logic [63:0] T_LO = exp_entry(Z_LO);
      localparam logic [63:0] T_DELTA = (T_LO > T_HI) ? 64'd0 : T_HI - T_LO;
      assign hi_rom[i]    = T_HI[SIDE_W-1:0];
      assign delta_rom[i] = T_DELTA[SIDE_W-1:0];
   end

   logic [SIDE_W-1:0] hi_ff;
   logic [SIDE_W-1:0] delta_ff;
   logic [FRAC_W-1:0] frac_ff;
   side_flags_type    flags_ff;
   logic [SIDE_W-1:0] side_ff;
   logic [SIDE_W-1:0] side_in;
   logic [SIDE_W+FRAC_W-1:0] slope;
   logic [IDX_W-1:0]  idx_rd;

   assign idx_rd = idx;

   always_ff @(posedge clock) begin
      if (ld[ST_READ]) begin
         hi_ff    <= hi_rom[idx_rd];
         delta_ff <= delta_rom[idx_rd];
         frac_ff  <= frac;
         flags_ff <= flags;
      end
   end

   always_comb begin
      slope = (SIDE_W+FRAC_W)'(delta_ff) * (SIDE_W+FRAC_W)'(frac_ff);
      if (!flags_ff.active) begin
         side_in = SIDE_ONE;
      end else if (flags_ff.sat) begin
         side_in = '0;
      end else begin
         side_in = hi_ff - slope[SIDE_W+FRAC_W-1:FRAC_W];
      end
   end

   always_ff @(posedge clock) begin
      if (ld[ST_INTERP]) begin
         side_ff <= side_in;
      end
   end

   assign side_value = side_ff;

endmodule

### hw/rtl/tsgm_side.sv
// One side of the membership function: square, scale, table index, then interpolation.
// Depends on tsgm_pkg and tsgm_exp_interp.
module tsgm_side import tsgm_pkg::*; #(
   parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
   input  logic              clock,
   input  stage_en_type      ld,
   input  logic [15:0]       distance,  // |x - c|, Q8.8
   input  logic              active,
   input  logic [23:0]       falloff,   // Q8.16
   output logic [SIDE_W-1:0] side_value
);

   localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);
   localparam int PROD_W = EXP_FRAC_BITS + $clog2(EXP_TABLE_DEPTH + 1);

   logic [31:0]              sq_ff;
   logic                     act_sq_ff;
   logic [55:0]              scaled;
   logic [EXP_FRAC_BITS-1:0] a_ff;
   side_flags_type           flags_a_ff;
   logic [PROD_W-1:0]        pos;
   logic [IDX_W-1:0]         idx_ff;
   logic [FRAC_W-1:0]        frac_ff;
   side_flags_type           flags_i_ff;

   always_ff @(posedge clock) begin
      if (ld[ST_SQUARE]) begin
         sq_ff     <= 32'(distance) * 32'(distance);
         act_sq_ff <= active;
      end
   end

   assign scaled = 56'(sq_ff) * 56'(falloff);

   always_ff @(posedge clock) begin
      if (ld[ST_SCALE]) begin
         a_ff              <= scaled[EXP_FRAC_BITS-1:0];
         flags_a_ff.active <= act_sq_ff;
         flags_a_ff.sat    <= |scaled[55:EXP_FRAC_BITS];
      end
   end

   // table position: a * depth / 16, integer part indexes, next 16 bits interpolate
   assign pos = PROD_W'(a_ff) * PROD_W'(EXP_TABLE_DEPTH);

   always_ff @(posedge clock) begin
      if (ld[ST_INDEX]) begin
         idx_ff     <= pos[EXP_FRAC_BITS +: IDX_W];
         frac_ff    <= pos[EXP_FRAC_BITS-1 -: FRAC_W];
         flags_i_ff <= flags_a_ff;
      end
   end

   tsgm_exp_interp #(
      .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
   ) u_interp (
      .clock      (clock),
      .ld         (ld),
      .idx        (idx_ff),
      .frac       (frac_ff),
      .flags      (flags_i_ff),
      .side_value (side_value)
   );

endmodule

### hw/rtl/two_sided_gaussian_membership_core.sv
// Two-sided Gaussian membership function: Q8.8 sample in, Q1.15 membership degree out.
// One sample per clock unless rsp_tready stalls; each result passes the seven-register
// pipeline (distance, square, scale, index, table read, interpolate, product). Each
// register stage holds when the one after it is full and not draining, so req_tready
// follows rsp_tready through the occupied stages only. Centers and falloffs are to be
// written through the csr port between runs; the block itself does not enforce this.
// Depends on tsgm_pkg, tsgm_side, tsgm_exp_interp and the assertion macro header.
`include "two_sided_gaussian_membership_core_macros.svh"

module two_sided_gaussian_membership_core import tsgm_pkg::*; #(
   parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [15:0]            req_tdata,    // [15:0] sample_value
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [15:0]            rsp_tdata,    // [15:0] membership
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   // configuration
   logic [15:0] left_center_ff,  left_center_in;
   logic [15:0] right_center_ff, right_center_in;
   logic [23:0] left_falloff_ff, left_falloff_in;
   logic [23:0] right_falloff_ff, right_falloff_in;

   always_comb begin
      left_center_in   = left_center_ff;
      right_center_in  = right_center_ff;
      left_falloff_in  = left_falloff_ff;
      right_falloff_in = right_falloff_ff;
      if (csr_wen) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEFT_CENTER:   left_center_in   = csr_wdata[15:0];
            CSR_RIGHT_CENTER:  right_center_in  = csr_wdata[15:0];
            CSR_LEFT_FALLOFF:  left_falloff_in  = csr_wdata;
            CSR_RIGHT_FALLOFF: right_falloff_in = csr_wdata;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_center_ff   <= CENTER_RESET;
         right_center_ff  <= CENTER_RESET;
         left_falloff_ff  <= FALLOFF_RESET;
         right_falloff_ff <= FALLOFF_RESET;
      end else begin
         left_center_ff   <= left_center_in;
         right_center_ff  <= right_center_in;
         left_falloff_ff  <= left_falloff_in;
         right_falloff_ff <= right_falloff_in;
      end
   end

   // pipeline control
   stage_en_type valid_ff, valid_in;
   stage_en_type stage_ok;
   stage_en_type prev_valid;
   stage_en_type ld;

   always_comb begin
      stage_ok[STAGES-1] = !valid_ff[STAGES-1] || rsp_tready;
      for (int s = STAGES - 2; s >= 0; s--) begin
         stage_ok[s] = !valid_ff[s] || stage_ok[s+1];
      end
   end

   assign prev_valid = {valid_ff[STAGES-2:0], req_tvalid};
   assign ld         = stage_ok & prev_valid;
   assign valid_in   = ld | (~stage_ok & valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_tready = stage_ok[ST_DIFF];

   // distance stage
   logic signed [16:0] diff_left;
   logic signed [16:0] diff_right;
   logic [15:0]        dist_left_ff,  dist_right_ff;
   logic               act_left_ff,   act_right_ff;

   assign diff_left  = {left_center_ff[15], left_center_ff} - {req_tdata[15], req_tdata};
   assign diff_right = {req_tdata[15], req_tdata} - {right_center_ff[15], right_center_ff};

   always_ff @(posedge clock) begin
      if (ld[ST_DIFF]) begin
         dist_left_ff  <= diff_left[15:0];
         dist_right_ff <= diff_right[15:0];
         act_left_ff   <= !diff_left[16] && (diff_left != '0);
         act_right_ff  <= !diff_right[16] && (diff_right != '0);
      end
   end

   logic [SIDE_W-1:0] left_side;
   logic [SIDE_W-1:0] right_side;

   tsgm_side #(
      .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
   ) u_left (
      .clock      (clock),
      .ld         (ld),
      .distance   (dist_left_ff),
      .active     (act_left_ff),
      .falloff    (left_falloff_ff),
      .side_value (left_side)
   );

   tsgm_side #(
      .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
   ) u_right (
      .clock      (clock),
      .ld         (ld),
      .distance   (dist_right_ff),
      .active     (act_right_ff),
      .falloff    (right_falloff_ff),
      .side_value (right_side)
   );

   // product and rounding, output register
   logic [2*SIDE_W-1:0] side_prod;
   logic [2*SIDE_W-1:0] side_round;
   logic [15:0]         membership_ff;

   assign side_prod  = (2*SIDE_W)'(left_side) * (2*SIDE_W)'(right_side);
   assign side_round = side_prod + ((2*SIDE_W)'(1) << 44);

   always_ff @(posedge clock) begin
      if (ld[ST_OUT]) begin
         membership_ff <= side_round[60:45];
      end
   end

   assign rsp_tvalid = valid_ff[ST_OUT];
   assign rsp_tdata  = membership_ff;

   `TSGM_ASSERT_SAME(a_member_range, rsp_tvalid, rsp_tdata <= MEMBERSHIP_ONE, "membership above one")
   `TSGM_ASSERT_NEXT(a_entry_lands, req_tvalid && req_tready, valid_ff[ST_DIFF], "transfer not captured")
   `TSGM_ASSERT_SAME(a_full_stall, (&valid_ff) && !rsp_tready, !req_tready, "accept while pipe full")
   `TSGM_ASSERT_NEXT(a_out_drains, rsp_tvalid && rsp_tready && !valid_ff[ST_OUT-1], !rsp_tvalid, "result repeated")

endmodule

### sim/membership_checker.sv
// Checker for the two-sided Gaussian membership core: watches the req, rsp and csr ports,
// predicts each membership degree from its own exp table and register copy, and compares.
// Depends on tsgm_pkg.
module membership_checker import tsgm_pkg::*; #(
   parameter int TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [15:0]            req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [15:0]            rsp_tdata,
   input  logic                   csr_wen,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   output int                     error_count,
   output int                     pending_count
);

   typedef struct packed {
      logic [15:0] sample;
      logic [15:0] degree;
   } degree_entry_type;

   logic [63:0]        exp_table [0:TABLE_DEPTH];
   logic signed [15:0] left_center;
   logic signed [15:0] right_center;
   logic [23:0]        left_falloff;
   logic [23:0]        right_falloff;
   degree_entry_type   expected_degrees [$];
   int                 shown;

   // exp(-16*i/TABLE_DEPTH) in Q2.30: Taylor series on a 1/32 slice, then squared five times
   function automatic logic [63:0] exp_decay_q30(input int i);
      logic [63:0] z;
      logic [63:0] sum;
      logic [63:0] term;
      z    = ((64'(i) << 30) + 64'(TABLE_DEPTH)) / 64'(2 * TABLE_DEPTH);
      sum  = 64'd1 << 30;
      term = sum;
      for (int n = 1; n <= 12; n++) begin
         term = ((term * z) >> 30) / 64'(n);
         if (n % 2 == 1) begin
            sum = (sum >= term) ? sum - term : 64'd0;
         end else begin
            sum = sum + term;
         end
      end
      for (int n = 0; n < 5; n++) begin
         sum = (sum * sum + (64'd1 << 29)) >> 30;
      end
      return sum;
   endfunction

   // exp(-distance^2 * falloff) in Q2.30, distance Q8.8, falloff Q8.16
   function automatic logic [63:0] side_weight(input logic [15:0] distance,
                                               input logic [23:0] falloff);
      logic [63:0] a;
      logic [63:0] p;
      logic [63:0] idx;
      logic [63:0] frac;
      logic [63:0] hi;
      logic [63:0] lo;
      a = 64'(distance) * 64'(distance) * 64'(falloff);
      if (a >= (64'd1 << 36)) begin
         return 64'd0;
      end
      p   = a * 64'(TABLE_DEPTH);
      idx = p >> 36;
      if (idx >= 64'(TABLE_DEPTH)) begin
         return 64'd0;
      end
      frac = (p >> 20) & 64'hFFFF;
      hi   = exp_table[int'(idx)];
      lo   = exp_table[int'(idx) + 1];
      if (lo > hi) begin
         lo = hi;
      end
      return hi - (((hi - lo) * frac) >> 16);
   endfunction

   function automatic logic [15:0] degree_of(input logic signed [15:0] x);
      int          diff;
      logic [63:0] left_side;
      logic [63:0] right_side;
      logic [63:0] prod;
      left_side  = 64'd1 << 30;
      right_side = 64'd1 << 30;
      if (x < left_center) begin
         diff      = int'(left_center) - int'(x);
         left_side = side_weight(16'(diff), left_falloff);
      end
      if (x > right_center) begin
         diff       = int'(x) - int'(right_center);
         right_side = side_weight(16'(diff), right_falloff);
      end
      prod = (left_side * right_side + (64'd1 << 44)) >> 45;
      return prod[15:0];
   endfunction

   task automatic report_mismatch(input string msg);
      if (shown < 100) begin
         $display("mismatch at %0t: %s", $time, msg);
      end
      shown++;
      error_count++;
   endtask

   initial begin
      error_count   = 0;
      pending_count = 0;
      shown         = 0;
      for (int i = 0; i <= TABLE_DEPTH; i++) begin
         exp_table[i] = exp_decay_q30(i);
      end
   end

   always @(posedge clock) begin : monitor
      degree_entry_type entry;
      if (reset) begin
         left_center   = CENTER_RESET;
         right_center  = CENTER_RESET;
         left_falloff  = FALLOFF_RESET;
         right_falloff = FALLOFF_RESET;
         expected_degrees.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_degrees.size() == 0) begin
               report_mismatch($sformatf("membership %0d with no sample outstanding",
                                         rsp_tdata));
            end else begin
               entry = expected_degrees.pop_front();
               if (rsp_tdata !== entry.degree) begin
                  report_mismatch($sformatf("sample %h: membership %0d, predicted %0d",
                                            entry.sample, rsp_tdata, entry.degree));
               end
            end
         end
         if (req_tvalid && req_tready) begin
            entry.sample = req_tdata;
            entry.degree = degree_of(req_tdata);
            expected_degrees.push_back(entry);
         end
         if (csr_wen) begin
            case (csr_index_type'(csr_index))
               CSR_LEFT_CENTER:   left_center   = csr_wdata[15:0];
               CSR_RIGHT_CENTER:  right_center  = csr_wdata[15:0];
               CSR_LEFT_FALLOFF:  left_falloff  = csr_wdata;
               CSR_RIGHT_FALLOFF: right_falloff = csr_wdata;
               default: ;
            endcase
         end
      end
      pending_count = expected_degrees.size();
   end

endmodule

### sim/testbench.sv
// Top of the membership core testbench: clock, reset, sample and csr stimulus, rsp stalls,
// idle watchdog and final verdict. Depends on tsgm_pkg, two_sided_gaussian_membership_core
// and membership_checker.
module testbench;
   import tsgm_pkg::*;

   localparam int IDLE_LIMIT      = 1000;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 225;
   localparam int SETTLE          = STAGES + 4;

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic [15:0]            req_tdata  = '0;
   logic                   rsp_tready = 1'b0;
   logic                   csr_wen    = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = CSR_LEFT_CENTER;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;
   logic                   req_tready;
   logic                   rsp_tvalid;
   logic [15:0]            rsp_tdata;

   int                 error_count;
   int                 pending_count;
   int                 stall_left  = 0;
   int                 idle_cycles = 0;
   bit                 idle_on     = 1'b0;
   logic signed [15:0] left_c      = '0;
   logic signed [15:0] right_c     = '0;

   two_sided_gaussian_membership_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   membership_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .csr_wen       (csr_wen),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always #1 clock = ~clock;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_tready <= 1'b0;
         stall_left <= $urandom_range(0, 3);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end
   end

   task automatic send_sample(input logic [15:0] value);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic load_profile(input logic [15:0] c1, input logic [15:0] c2,
                               input logic [23:0] k1, input logic [23:0] k2);
      csr_wen   <= 1'b1;
      csr_index <= CSR_LEFT_CENTER;
      csr_wdata <= {8'($urandom), c1};
      @(posedge clock);
      csr_index <= CSR_RIGHT_CENTER;
      csr_wdata <= {8'($urandom), c2};
      @(posedge clock);
      csr_index <= CSR_LEFT_FALLOFF;
      csr_wdata <= k1;
      @(posedge clock);
      csr_index <= CSR_RIGHT_FALLOFF;
      csr_wdata <= k2;
      @(posedge clock);
      csr_wen <= 1'b0;
      left_c  = c1;
      right_c = c2;
      @(posedge clock);
   endtask

   function automatic logic [15:0] random_center();
      if ($urandom_range(0, 3) == 0) begin
         return 16'($urandom);
      end
      return 16'($signed(16'($urandom)) >>> 4);
   endfunction

   function automatic logic [23:0] random_falloff();
      case ($urandom_range(0, 5))
         0:       return 24'h000000;
         1:       return 24'hFFFFFF;
         2:       return 24'($urandom_range(1, 255));
         3:       return 24'($urandom_range(256, 24'h03FFFF));
         default: return 24'($urandom);
      endcase
   endfunction

   // mostly near one of the shoulders, spread over all scales
   function automatic logic [15:0] random_sample();
      logic [15:0] spread;
      logic [15:0] center;
      spread = 16'($signed(16'($urandom)) >>> $urandom_range(0, 15));
      center = ($urandom_range(0, 1) == 1) ? left_c : right_c;
      case ($urandom_range(0, 4))
         0:       return 16'($urandom);
         1:       return center;
         2:       return center + 16'($urandom_range(0, 2)) - 16'd1;
         default: return center + spread;
      endcase
   endfunction

   initial begin
      repeat (6) @(posedge clock);
      reset   <= 1'b0;
      idle_on = 1'b1;

      // reset profile: both centers at zero, unit falloff; 4.0 away gives exponent 16
      send_sample(16'h0000);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h0001);
      send_sample(16'hFFFF);
      send_sample(16'h0400);
      send_sample(16'hFC00);
      send_sample(16'h03FF);
      send_sample(16'h0180);
      wait_drained();

      // crossed shoulders, zero left falloff, full right falloff
      load_profile(16'h0200, 16'hFE00, 24'h000000, 24'hFFFFFF);
      send_sample(16'h0200);
      send_sample(16'hFE00);
      send_sample(16'h0000);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'hFE01);
      wait_drained();

      // widest distances with the smallest falloff
      load_profile(16'h7FFF, 16'h8000, 24'h000001, 24'h000001);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h0000);
      wait_drained();

      load_profile(16'h8000, 16'h7FFF, 24'hFFFFFF, 24'h000000);
      send_sample(16'h8000);
      send_sample(16'h7FFF);
      send_sample(16'h1234);
      wait_drained();

      for (int phase = 0; phase < PHASES; phase++) begin
         idle_on = (phase != PHASES - 1) && (phase % 3 != 1);
         load_profile(random_center(), random_center(), random_falloff(), random_falloff());
         repeat (ITEMS_PER_PHASE) send_sample(random_sample());
         wait_drained();
      end

      if (error_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/tsgm_pkg.sv
hw/rtl/tsgm_exp_interp.sv
hw/rtl/tsgm_side.sv
hw/rtl/two_sided_gaussian_membership_core.sv
sim/membership_checker.sv
sim/testbench.sv
